[hdl/unicycle_trajectory_rollout_core_assert.svh]
// Assertion macros for the unicycle trajectory rollout block.
// Used by utr_checker; expects clk and rst_n in scope.
`ifndef UNICYCLE_TRAJECTORY_ROLLOUT_CORE_ASSERT_SVH
`define UNICYCLE_TRAJECTORY_ROLLOUT_CORE_ASSERT_SVH

// same-cycle implication
`define UTR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utr assertion failed");

// next-cycle implication
`define UTR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utr assertion failed");

`endif

[hdl/utr_pkg.sv]
// Shared types, constants and helper functions of the trajectory rollout block.
// No dependencies.
package utr_pkg;

  localparam int MAX_POINTS    = 64;
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_W      = 32;
  localparam int ITER_W        = $clog2(CORDIC_STAGES + 1);
  localparam int PROD_W        = 49;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
  // round half up before the shift by 30
  localparam logic signed [PROD_W-1:0]   ROUND_HALF  = 49'sd536870912;

  typedef enum logic [1:0] {
    REG_STEP_LENGTH = 2'd0,
    REG_FIRST_TURN  = 2'd1,
    REG_TURN_STEP   = 2'd2,
    REG_POINT_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CORDIC,
    ST_MUL_S,
    ST_MUL_C,
    ST_UPDATE
  } seq_state_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_val(input logic [4:0] idx);
    logic signed [CORDIC_W-1:0] r;
    case (idx)
      5'd0:  r = 32'sd536870912;
      5'd1:  r = 32'sd316933406;
      5'd2:  r = 32'sd167458907;
      5'd3:  r = 32'sd85004756;
      5'd4:  r = 32'sd42667331;
      5'd5:  r = 32'sd21354465;
      5'd6:  r = 32'sd10679838;
      5'd7:  r = 32'sd5340245;
      5'd8:  r = 32'sd2670163;
      5'd9:  r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41722;
      5'd15: r = 32'sd20861;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2608;
      5'd19: r = 32'sd1304;
      5'd20: r = 32'sd652;
      5'd21: r = 32'sd326;
      5'd22: r = 32'sd163;
      5'd23: r = 32'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[hdl/utr_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, sin/cos of a
// 16-bit binary angle scaled by 2^30. Depends on utr_pkg.
module utr_cordic import utr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [15:0]                angle,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] sin_val,
  output logic signed [CORDIC_W-1:0] cos_val
);

  logic signed [CORDIC_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [CORDIC_W-1:0] sin_r, sin_nxt, cos_r, cos_nxt;
  logic signed [CORDIC_W-1:0] dx, dy, at;
  logic [1:0]                 quad_r, quad_nxt;
  logic [ITER_W-1:0]          iter_r, iter_nxt;
  logic                       busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    dx       = y_r >>> iter_r;
    dy       = x_r >>> iter_r;
    at       = atan_val(5'(iter_r));
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    quad_nxt = quad_r;
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sin_nxt  = sin_r;
    cos_nxt  = cos_r;
    if (start) begin
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = {2'b00, angle[13:0], 16'h0000};
      quad_nxt = angle[15:14];
      iter_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (iter_r == ITER_W'(CORDIC_STAGES)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        // quadrant fold-back
        case (quad_r)
          2'd0: begin cos_nxt = x_r;  sin_nxt = y_r;  end
          2'd1: begin cos_nxt = -y_r; sin_nxt = x_r;  end
          2'd2: begin cos_nxt = -x_r; sin_nxt = -y_r; end
          default: begin cos_nxt = y_r; sin_nxt = -x_r; end
        endcase
      end else begin
        if (!z_r[CORDIC_W-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        iter_nxt = iter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    quad_r <= quad_nxt;
    sin_r  <= sin_nxt;
    cos_r  <= cos_nxt;
  end

  assign done    = done_r;
  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

[hdl/unicycle_trajectory_rollout_core.sv]
// Unicycle trajectory rollout: one input item yields point_count result items,
// clamped to 1..MAX_POINTS. The origin is registered in ST_LOAD once the output
// is free; each further point runs the 16-iteration CORDIC, then the shared
// scaling multiplier. A new item waits until the last point is registered.
// Reset (synchronous, rst_n low) returns to idle and loads the register defaults.
module unicycle_trajectory_rollout_core import utr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_robot_heading,
  input  logic [5:0]         in_trajectory_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic [15:0]        out_heading_offset,
  output logic [5:0]         out_point_index,
  output logic               out_last
);

  // configuration
  logic [15:0] step_length_r, first_turn_r, turn_step_r;
  logic [6:0]  point_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r <= 16'd128;
      first_turn_r  <= 16'heba1;
      turn_step_r   <= 16'd1159;
      point_count_r <= 7'd10;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_LENGTH: step_length_r <= cfg_wdata;
        REG_FIRST_TURN:  first_turn_r  <= cfg_wdata;
        REG_TURN_STEP:   turn_step_r   <= cfg_wdata;
        REG_POINT_COUNT: point_count_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  seq_state_t state_r, state_nxt;
  logic [15:0] heading_r, heading_nxt, turn_r, turn_nxt, half_r, half_nxt;
  logic [15:0] off_r, off_nxt;
  logic [5:0]  idx_r, idx_nxt, last_idx_r, last_idx_nxt;
  logic signed [15:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  logic        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic signed [15:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [15:0] out_off_r, out_off_nxt;
  logic [5:0]  out_idx_r, out_idx_nxt;

  logic        cordic_start, cordic_done;
  logic [15:0] cordic_angle, turn_calc;
  logic [21:0] turn_prod;
  logic signed [CORDIC_W-1:0] sin_val, cos_val, mul_op;
  logic signed [18:0] delta;
  logic signed [19:0] sum_x, sum_y;
  logic        is_last;

  utr_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .angle   (cordic_angle),
    .done    (cordic_done),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  assign turn_prod    = in_trajectory_index * turn_step_r;
  assign turn_calc    = first_turn_r + turn_prod[15:0];
  assign cordic_angle = heading_r + off_r + half_r;
  assign is_last      = (idx_r == last_idx_r);
  // scaled displacement, Q10.8
  assign delta        = prod_r[PROD_W-1:30];
  assign sum_x        = 20'(px_r) - 20'(delta);
  assign sum_y        = 20'(py_r) + 20'(delta);
  assign mul_op       = (state_r == ST_MUL_S) ? sin_val : cos_val;

  always_comb begin
    state_nxt     = state_r;
    heading_nxt   = heading_r;
    turn_nxt      = turn_r;
    half_nxt      = half_r;
    off_nxt       = off_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    prod_nxt      = $signed({1'b0, step_length_r}) * mul_op + ROUND_HALF;
    out_valid_nxt = out_valid_r && !out_ready;
    out_last_nxt  = out_last_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_off_nxt   = out_off_r;
    out_idx_nxt   = out_idx_r;
    cordic_start  = 1'b0;
    in_ready      = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          heading_nxt = in_robot_heading;
          turn_nxt    = turn_calc;
          half_nxt    = {turn_calc[15], turn_calc[15:1]};
          off_nxt     = '0;
          idx_nxt     = '0;
          px_nxt      = '0;
          py_nxt      = '0;
          if (point_count_r == 7'd0) begin
            last_idx_nxt = '0;
          end else if (point_count_r > 7'(MAX_POINTS)) begin
            last_idx_nxt = 6'(MAX_POINTS - 1);
          end else begin
            last_idx_nxt = 6'(point_count_r - 7'd1);
          end
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = px_r;
          out_y_nxt     = py_r;
          out_off_nxt   = off_r;
          out_idx_nxt   = idx_r;
          out_last_nxt  = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cordic_start = 1'b1;
            state_nxt    = ST_CORDIC;
          end
        end
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          state_nxt = ST_MUL_S;
        end
      end
      ST_MUL_S: begin
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        px_nxt    = sat16(sum_x);
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        py_nxt    = sat16(sum_y);
        off_nxt   = off_r + turn_r;
        idx_nxt   = idx_r + 6'd1;
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    heading_r  <= heading_nxt;
    turn_r     <= turn_nxt;
    half_r     <= half_nxt;
    off_r      <= off_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    prod_r     <= prod_nxt;
    out_last_r <= out_last_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_off_r  <= out_off_nxt;
    out_idx_r  <= out_idx_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_pos_x          = out_x_r;
  assign out_pos_y          = out_y_r;
  assign out_heading_offset = out_off_r;
  assign out_point_index    = out_idx_r;
  assign out_last           = out_last_r;

endmodule

[hdl/utr_checker.sv]
// Port-level checks of the trajectory rollout block, bound to the top level.
// Depends on unicycle_trajectory_rollout_core_assert.svh.
`include "unicycle_trajectory_rollout_core_assert.svh"

module utr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_pos_x,
  input logic signed [15:0] out_pos_y,
  input logic [15:0]        out_heading_offset,
  input logic [5:0]         out_point_index,
  input logic               out_last
);

  logic out_stalled, out_origin, origin_zero;

  assign out_stalled = out_valid && !out_ready;
  assign out_origin  = out_valid && (out_point_index == 6'd0);
  assign origin_zero = (out_pos_x == 16'sd0) && (out_pos_y == 16'sd0) &&
                       (out_heading_offset == 16'd0);

  // a stalled result item holds
  `UTR_ASSERT_NXT(a_out_hold, out_stalled, out_valid && $stable(out_pos_x) && $stable(out_pos_y))

  // busy right after taking an item
  `UTR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // origin point carries zero position and offset
  `UTR_ASSERT_IMP(a_origin_zero, out_origin, origin_zero)

  // no new item while a trajectory still has points to go
  `UTR_ASSERT_IMP(a_no_accept_mid_traj, out_valid && !out_last, !in_ready)

endmodule

bind unicycle_trajectory_rollout_core utr_checker u_utr_checker (.*);

[bench/tb_unicycle_trajectory_rollout_core.sv]
// Self-checking bench for unicycle_trajectory_rollout_core: predicts every point of each
// rolled-out trajectory and compares it field by field. Depends on utr_pkg and the core RTL.
module tb_unicycle_trajectory_rollout_core import utr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 50;

  // arctangent of 2^-i in 2^-32 turn
  localparam longint ATAN_TURN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        heading_offset;
    logic [5:0]         point_index;
    logic               last;
  } point_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        in_robot_heading;
  logic [5:0]         in_trajectory_index;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic [15:0]        out_heading_offset;
  logic [5:0]         out_point_index;
  logic               out_last;

  // register mirror
  logic [15:0] step_len_q;
  logic [15:0] first_turn_q;
  logic [15:0] turn_step_q;
  logic [6:0]  point_count_q;

  point_t pending_points[$];
  int     fail_count = 0;
  int     out_stall = 0;
  bit     steady_flow = 1'b0;

  unicycle_trajectory_rollout_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_robot_heading    (in_robot_heading),
    .in_trajectory_index (in_trajectory_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pos_x           (out_pos_x),
    .out_pos_y           (out_pos_y),
    .out_heading_offset  (out_heading_offset),
    .out_point_index     (out_point_index),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("unicycle_trajectory_rollout_core verification failed");
    $finish;
  end

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // sin and cos of a binary angle, both scaled by 2^30
  function automatic void cordic_sincos(input logic [15:0] ang, output longint s,
                                        output longint c);
    longint x, y, z, dx, dy;
    x = longint'(CORDIC_GAIN);
    y = 0;
    z = {ang[13:0], 16'h0000};
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    case (ang[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint scale_step(input longint v);
    longint sl;
    sl = step_len_q;
    return (sl * v + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [15:0] clamp_q78(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // queue every point of one trajectory
  function automatic void roll_trajectory(input logic [15:0] heading, input logic [5:0] traj);
    logic [15:0]        turn, half, offset, mid;
    logic signed [15:0] px, py;
    longint             s, c;
    int                 n;
    point_t             p;
    turn = first_turn_q + 16'(traj) * turn_step_q;
    half = {turn[15], turn[15:1]};
    if (point_count_q == 0) begin
      n = 1;
    end else if (point_count_q > MAX_POINTS) begin
      n = MAX_POINTS;
    end else begin
      n = point_count_q;
    end
    offset = '0;
    px = '0;
    py = '0;
    for (int j = 0; j < n; j++) begin
      p.pos_x = px;
      p.pos_y = py;
      p.heading_offset = offset;
      p.point_index = 6'(j);
      p.last = (j == n - 1);
      pending_points = {pending_points, p};
      if (j != n - 1) begin
        mid = heading + offset + half;
        cordic_sincos(mid, s, c);
        px = clamp_q78(longint'(px) - scale_step(s));
        py = clamp_q78(longint'(py) + scale_step(c));
        offset = offset + turn;
      end
    end
  endfunction

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      out_stall = idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point: pos_x %0d pos_y %0d point_index %0d",
               out_pos_x, out_pos_y, out_point_index);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, actual %0d", want.pos_x, out_pos_x);
          fail_count++;
        end
        if (out_pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, actual %0d", want.pos_y, out_pos_y);
          fail_count++;
        end
        if (out_heading_offset !== want.heading_offset) begin
          $error("heading_offset: expected %0d, actual %0d",
                 want.heading_offset, out_heading_offset);
          fail_count++;
        end
        if (out_point_index !== want.point_index) begin
          $error("point_index: expected %0d, actual %0d", want.point_index, out_point_index);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [15:0] heading, input logic [5:0] traj);
    int gap;
    gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_robot_heading <= heading;
    in_trajectory_index <= traj;
    do @(posedge clk); while (!in_ready);
    roll_trajectory(heading, traj);
  endtask

  task automatic drain_points();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_STEP_LENGTH: step_len_q = value;
      REG_FIRST_TURN:  first_turn_q = value;
      REG_TURN_STEP:   turn_step_q = value;
      REG_POINT_COUNT: point_count_q = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_rollout(input logic [15:0] step, input logic [15:0] first,
                             input logic [15:0] tstep, input logic [15:0] count);
    drain_points();
    write_reg(REG_STEP_LENGTH, step);
    write_reg(REG_FIRST_TURN, first);
    write_reg(REG_TURN_STEP, tstep);
    write_reg(REG_POINT_COUNT, count);
  endtask

  task automatic test_reset_defaults();
    send_item(16'h0000, 6'd0);
    send_item(16'hffff, 6'd63);
    send_item(16'h4000, 6'd5);
    send_item(16'h8000, 6'd31);
  endtask

  // longest step, sharpest turns, full-length trajectories: positions saturate
  task automatic test_extreme_settings();
    set_rollout(16'hffff, 16'h8000, 16'h7fff, 16'd64);
    send_item(16'h2000, 6'd0);
    send_item(16'hc000, 6'd63);
    send_item(16'h0001, 6'd1);
  endtask

  task automatic test_count_clamping();
    // zero count acts as one point, zero step stays at the origin
    set_rollout(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'h1234, 6'd7);
    send_item(16'hffff, 6'd63);
    // count far above the maximum, straight line
    set_rollout(16'h0100, 16'h0000, 16'h0000, 16'hff7f);
    send_item(16'hc000, 6'd0);
    // just above the maximum; turn of -1 has an odd negative half
    set_rollout(16'h0080, 16'hffff, 16'h0001, 16'd65);
    send_item(16'h0000, 6'd0);
    send_item(16'h0000, 6'd1);
    send_item(16'h5555, 6'd2);
    set_rollout(16'h0200, 16'h0400, 16'hfc00, 16'd2);
    send_item(16'h7fff, 6'd63);
    send_item(16'h8001, 6'd32);
  endtask

  task automatic test_random_fans();
    logic [15:0] step, count;
    int          pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      step = ($urandom_range(0, 4) == 0) ? 16'hffff : 16'($urandom_range(0, 65535));
      count = 16'($urandom_range(0, 65535));
      if (pick == 0) begin
        count[6:0] = 7'($urandom_range(65, 127));
      end else if (pick == 1) begin
        count[6:0] = 7'd0;
      end else begin
        count[6:0] = 7'($urandom_range(1, 16));
      end
      set_rollout(step, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), count);
      steady_flow = (ph % 4 == 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_item(16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)));
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_STEP_LENGTH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_robot_heading = '0;
    in_trajectory_index = '0;
    out_ready = 1'b0;
    step_len_q = 16'd128;
    first_turn_q = 16'hEBA1;  // -5215
    turn_step_q = 16'd1159;
    point_count_q = 7'd10;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_extreme_settings();
    test_count_clamping();
    test_random_fans();
    drain_points();
    // stray points would show up here
    repeat (60) @(posedge clk);

    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("unicycle_trajectory_rollout_core verification clean");
    end else begin
      $display("unicycle_trajectory_rollout_core verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/utr_pkg.sv
hdl/utr_cordic.sv
hdl/unicycle_trajectory_rollout_core.sv
hdl/utr_checker.sv
bench/tb_unicycle_trajectory_rollout_core.sv
